@@ src/gfs_pkg.sv @@
// ----------------------------------------------------------------------------
// gfs_pkg: shared types and constants for the glass scatter block
// Fixed-point field types, configuration sequencer states and stage indexes.
// ----------------------------------------------------------------------------
package gfs_pkg;

  typedef logic signed [15:0] dir_t;
  typedef logic [15:0]        col_t;
  typedef logic [15:0]        frac_t;
  typedef logic [13:0]        ior_t;

  typedef enum logic [1:0] {
    CFG_SQ,
    CFG_DIV,
    CFG_RUN
  } cfg_state_t;

  localparam ior_t IOR_ONE   = 14'd4096;
  localparam ior_t IOR_RESET = 14'd6144;

  localparam int DIV_STEPS      = 32;
  localparam int LANE_DIV_STEPS = 16;
  localparam int SQRT_STEPS     = 15;
  localparam int R0_STEPS       = 16;

  localparam int STG_IN   = 0;
  localparam int STG_MUL  = 1;
  localparam int STG_INIT = 2;
  localparam int STG_DIV0 = 3;
  localparam int STG_SEL  = STG_DIV0 + DIV_STEPS;
  localparam int STG_SQ0  = STG_SEL + 1;
  localparam int STG_COS  = STG_SQ0 + SQRT_STEPS;
  localparam int STG_P2   = STG_COS + 1;
  localparam int STG_P4   = STG_P2 + 1;
  localparam int STG_P5   = STG_P4 + 1;
  localparam int STG_FM   = STG_P5 + 1;
  localparam int STG_LAST = STG_FM;

  localparam logic [14:0] Q14_ONE = 15'd16384;
  localparam logic [16:0] Q16_ONE = 17'd65536;
  localparam logic [34:0] ST2_ONE = 35'd268435456;

endpackage

@@ src/gfs_if.sv @@
// ----------------------------------------------------------------------------
// gfs channel interfaces
// Valid/ready channels for configuration, ray input and scatter result.
// ----------------------------------------------------------------------------
interface gfs_cfg_if import gfs_pkg::*; ();
  logic valid;
  logic ready;
  ior_t ior;
  modport source (output valid, output ior, input ready);
  modport sink (input valid, input ior, output ready);
endinterface

interface gfs_in_if import gfs_pkg::*; ();
  logic  valid;
  logic  ready;
  dir_t  dir_x;
  dir_t  dir_y;
  dir_t  dir_z;
  col_t  refl_r;
  col_t  refl_g;
  col_t  refl_b;
  col_t  trans_r;
  col_t  trans_g;
  col_t  trans_b;
  frac_t rand_uniform;
  modport source (output valid, output dir_x, output dir_y, output dir_z,
                  output refl_r, output refl_g, output refl_b,
                  output trans_r, output trans_g, output trans_b,
                  output rand_uniform, input ready);
  modport sink (input valid, input dir_x, input dir_y, input dir_z,
                input refl_r, input refl_g, input refl_b,
                input trans_r, input trans_g, input trans_b,
                input rand_uniform, output ready);
endinterface

interface gfs_out_if import gfs_pkg::*; ();
  logic valid;
  logic ready;
  dir_t new_x;
  dir_t new_y;
  dir_t new_z;
  col_t atten_r;
  col_t atten_g;
  col_t atten_b;
  logic total_internal;
  logic took_reflect;
  modport source (output valid, output new_x, output new_y, output new_z,
                  output atten_r, output atten_g, output atten_b,
                  output total_internal, output took_reflect, input ready);
  modport sink (input valid, input new_x, input new_y, input new_z,
                input atten_r, input atten_g, input atten_b,
                input total_internal, input took_reflect, output ready);
endinterface

@@ src/glass_fresnel_scatter.sv @@
// ----------------------------------------------------------------------------
// glass_fresnel_scatter: Snell refraction with Schlick Fresnel selection
// Throughput: one ray per cycle while the skid spare entry is empty and no setup runs;
// 56 register stages plus a two-entry output skid.
// Reset and each ior write run a setup (ior squares, Fresnel r0
// by a 16-step divider) during which in.ready and cfg.ready stay low.
// ----------------------------------------------------------------------------
module glass_fresnel_scatter import gfs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  gfs_cfg_if.sink     cfg_ch,
  gfs_in_if.sink      in_ch,
  gfs_out_if.source   out_ch
);

  typedef struct packed {
    logic               vac;
    logic               tir;
    dir_t               x;
    dir_t               y;
    dir_t               z;
    logic [15:0]        ax;
    logic [15:0]        az;
    col_t [2:0]         refl;
    col_t [2:0]         trans;
    frac_t              rnd;
    logic [31:0]        s2;
    logic [1:0][16:0]   m_mat;
    col_t [2:0]         ta_vac;
    logic [34:0]        st2_mat;
    logic [27:0]        d_rem;
    logic [31:0]        d_num;
    logic [31:0]        d_q;
    logic [1:0][13:0]   c_rem;
    logic [1:0][15:0]   c_num;
    logic [1:0][15:0]   c_q;
    logic [2:0][27:0]   t_rem;
    col_t [2:0]         t_q;
    logic [28:0]        sq_v;
    logic [29:0]        sq_res;
    logic [14:0]        cos_t;
    logic [14:0]        c;
    logic [14:0]        p2;
    logic [14:0]        p4;
    logic [14:0]        p5;
    logic [16:0]        fm;
  } item_t;

  typedef struct packed {
    dir_t new_x;
    dir_t new_y;
    dir_t new_z;
    col_t atten_r;
    col_t atten_g;
    col_t atten_b;
    logic total_internal;
    logic took_reflect;
  } res_t;

  localparam int CNT_W = $clog2(R0_STEPS);

  cfg_state_t         st_r, st_nxt;
  logic [CNT_W-1:0]   cnt_r;
  ior_t               n_r;
  logic [27:0]        n2_r;
  logic [28:0]        den2_r;
  logic [28:0]        rem_r;
  logic [15:0]        r0_r;
  logic               run;
  logic               cfg_fire;
  logic [29:0]        r0_sh;

  logic               en;
  logic               in_fire;
  logic [STG_LAST:0]  v_r;
  item_t              pipe_r   [0:STG_LAST];
  item_t              pipe_nxt [0:STG_LAST];
  res_t               res;
  res_t               out_d_r, out_d_nxt, spare_d_r, spare_d_nxt;
  logic               out_v_r, out_v_nxt, spare_v_r, spare_v_nxt;
  logic               push, pop;

  function automatic dir_t neg_sat(dir_t v);
    dir_t r;
    r = (v == 16'sh8000) ? 16'sh7fff : 16'(-v);
    return r;
  endfunction

  function automatic dir_t refr_sat(dir_t v, logic [16:0] m);
    dir_t r;
    if (v > 16'sd0) begin
      r = (m >= 17'd32768) ? 16'sh8000 : 16'(~m[15:0] + 16'd1);
    end else begin
      r = (m > 17'd32767) ? 16'sh7fff : m[15:0];
    end
    return r;
  endfunction

  function automatic item_t f_in();
    item_t q;
    q = '0;
    q.x        = in_ch.dir_x;
    q.y        = in_ch.dir_y;
    q.z        = in_ch.dir_z;
    q.vac      = ~in_ch.dir_y[15];
    q.ax       = in_ch.dir_x[15] ? 16'(-in_ch.dir_x) : in_ch.dir_x;
    q.az       = in_ch.dir_z[15] ? 16'(-in_ch.dir_z) : in_ch.dir_z;
    q.refl[0]  = in_ch.refl_r;
    q.refl[1]  = in_ch.refl_g;
    q.refl[2]  = in_ch.refl_b;
    q.trans[0] = in_ch.trans_r;
    q.trans[1] = in_ch.trans_g;
    q.trans[2] = in_ch.trans_b;
    q.rnd      = in_ch.rand_uniform;
    return q;
  endfunction

  function automatic item_t f_mul(item_t p, ior_t n, logic [27:0] n2);
    item_t       q;
    logic [43:0] tp;
    q = p;
    q.s2 = (32'(p.ax) * 32'(p.ax)) + (32'(p.az) * 32'(p.az));
    q.m_mat[0] = 17'((30'(p.ax) * 30'(n)) >> 12);
    q.m_mat[1] = 17'((30'(p.az) * 30'(n)) >> 12);
    for (int j = 0; j < 3; j++) begin
      tp = 44'(p.trans[j]) * 44'(n2);
      q.ta_vac[j] = (tp[43:40] != 4'd0) ? 16'hffff : tp[39:24];
    end
    return q;
  endfunction

  function automatic item_t f_init(item_t p, logic [27:0] n2);
    item_t       q;
    logic [59:0] sp;
    q = p;
    sp = 60'(p.s2) * 60'(n2);
    q.st2_mat  = sp[58:24];
    q.d_rem    = 28'(p.s2 >> 8);
    q.d_num    = {p.s2[7:0], 24'd0};
    q.d_q      = '0;
    q.c_rem[0] = 14'(p.ax >> 4);
    q.c_rem[1] = 14'(p.az >> 4);
    q.c_num[0] = {p.ax[3:0], 12'd0};
    q.c_num[1] = {p.az[3:0], 12'd0};
    q.c_q      = '0;
    for (int j = 0; j < 3; j++) begin
      q.t_rem[j] = {4'd0, p.trans[j], 8'd0};
    end
    q.t_q = '0;
    return q;
  endfunction

  function automatic item_t f_div(item_t p, int i, ior_t n, logic [27:0] n2);
    item_t       q;
    logic [28:0] r2;
    logic [14:0] c2;
    logic [28:0] t2;
    q = p;
    r2 = {p.d_rem, p.d_num[31]};
    q.d_num = {p.d_num[30:0], 1'b0};
    if (r2 >= {1'b0, n2}) begin
      q.d_rem = 28'(r2 - {1'b0, n2});
      q.d_q   = {p.d_q[30:0], 1'b1};
    end else begin
      q.d_rem = r2[27:0];
      q.d_q   = {p.d_q[30:0], 1'b0};
    end
    if (i < LANE_DIV_STEPS) begin
      for (int j = 0; j < 2; j++) begin
        c2 = {p.c_rem[j], p.c_num[j][15]};
        q.c_num[j] = {p.c_num[j][14:0], 1'b0};
        if (c2 >= {1'b0, n}) begin
          q.c_rem[j] = 14'(c2 - {1'b0, n});
          q.c_q[j]   = {p.c_q[j][14:0], 1'b1};
        end else begin
          q.c_rem[j] = c2[13:0];
          q.c_q[j]   = {p.c_q[j][14:0], 1'b0};
        end
      end
      for (int j = 0; j < 3; j++) begin
        t2 = {p.t_rem[j], 1'b0};
        if (t2 >= {1'b0, n2}) begin
          q.t_rem[j] = 28'(t2 - {1'b0, n2});
          q.t_q[j]   = {p.t_q[j][14:0], 1'b1};
        end else begin
          q.t_rem[j] = t2[27:0];
          q.t_q[j]   = {p.t_q[j][14:0], 1'b0};
        end
      end
    end
    return q;
  endfunction

  function automatic item_t f_sel(item_t p);
    item_t       q;
    logic [34:0] st2;
    q = p;
    st2 = p.vac ? {3'd0, p.d_q} : p.st2_mat;
    q.tir    = (st2 > ST2_ONE);
    q.sq_v   = q.tir ? 29'd0 : 29'(ST2_ONE - st2);
    q.sq_res = '0;
    return q;
  endfunction

  function automatic item_t f_sqrt(item_t p, int j);
    item_t       q;
    logic [29:0] sbit;
    logic [29:0] trial;
    q = p;
    sbit  = 30'd1 << (28 - 2 * j);
    trial = p.sq_res + sbit;
    if ({1'b0, p.sq_v} >= trial) begin
      q.sq_v   = 29'({1'b0, p.sq_v} - trial);
      q.sq_res = (p.sq_res >> 1) + sbit;
    end else begin
      q.sq_res = p.sq_res >> 1;
    end
    return q;
  endfunction

  function automatic item_t f_poly(item_t p, int s, logic [15:0] r0);
    item_t       q;
    logic [29:0] pr;
    logic [31:0] fp;
    q = p;
    pr = '0;
    fp = '0;
    if (s == STG_COS) begin
      q.cos_t = p.sq_res[14:0];
      q.c     = Q14_ONE - p.sq_res[14:0];
    end else if (s == STG_P2) begin
      pr   = 30'(p.c) * 30'(p.c);
      q.p2 = pr[28:14];
    end else if (s == STG_P4) begin
      pr   = 30'(p.p2) * 30'(p.p2);
      q.p4 = pr[28:14];
    end else if (s == STG_P5) begin
      pr   = 30'(p.p4) * 30'(p.c);
      q.p5 = pr[28:14];
    end else begin
      fp   = 32'(Q16_ONE - {1'b0, r0}) * 32'(p.p5);
      q.fm = fp[30:14];
    end
    return q;
  endfunction

  // configuration sequencer
  assign cfg_fire = cfg_ch.valid & cfg_ch.ready;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      CFG_SQ:  st_nxt = CFG_DIV;
      CFG_DIV: if (cnt_r == CNT_W'(R0_STEPS - 1)) st_nxt = CFG_RUN;
      CFG_RUN: if (cfg_fire) st_nxt = CFG_SQ;
      default: st_nxt = CFG_SQ;
    endcase
  end

  always_comb begin
    run = 1'b0;
    unique case (st_r)
      CFG_RUN: run = 1'b1;
      default: run = 1'b0;
    endcase
  end

  assign cfg_ch.ready = run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= CFG_SQ;
      n_r   <= IOR_RESET;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= (st_r == CFG_DIV) ? cnt_r + CNT_W'(1) : '0;
      if (cfg_fire) begin
        n_r <= (cfg_ch.ior < IOR_ONE) ? IOR_ONE : cfg_ch.ior;
      end
    end
  end

  assign r0_sh = {rem_r, 1'b0};

  always_ff @(posedge clk) begin
    if (st_r == CFG_SQ) begin
      n2_r   <= 28'(n_r) * 28'(n_r);
      rem_r  <= 29'(28'(n_r - IOR_ONE) * 28'(n_r - IOR_ONE));
      den2_r <= 29'({1'b0, n_r} + {1'b0, IOR_ONE}) * 29'({1'b0, n_r} + {1'b0, IOR_ONE});
      r0_r   <= '0;
    end else if (st_r == CFG_DIV) begin
      if (r0_sh >= {1'b0, den2_r}) begin
        rem_r <= 29'(r0_sh - {1'b0, den2_r});
        r0_r  <= {r0_r[14:0], 1'b1};
      end else begin
        rem_r <= r0_sh[28:0];
        r0_r  <= {r0_r[14:0], 1'b0};
      end
    end
  end

  // datapath pipeline
  assign en          = ~spare_v_r;
  assign in_ch.ready = en & run;
  assign in_fire     = in_ch.valid & in_ch.ready;

  always_comb begin
    pipe_nxt[STG_IN]   = f_in();
    pipe_nxt[STG_MUL]  = f_mul(pipe_r[STG_IN], n_r, n2_r);
    pipe_nxt[STG_INIT] = f_init(pipe_r[STG_MUL], n2_r);
    for (int i = 0; i < DIV_STEPS; i++) begin
      pipe_nxt[STG_DIV0 + i] = f_div(pipe_r[STG_DIV0 + i - 1], i, n_r, n2_r);
    end
    pipe_nxt[STG_SEL] = f_sel(pipe_r[STG_SEL - 1]);
    for (int j = 0; j < SQRT_STEPS; j++) begin
      pipe_nxt[STG_SQ0 + j] = f_sqrt(pipe_r[STG_SQ0 + j - 1], j);
    end
    for (int s = STG_COS; s <= STG_FM; s++) begin
      pipe_nxt[s] = f_poly(pipe_r[s - 1], s, r0_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STG_LAST-1:0], in_fire};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r <= pipe_nxt;
    end
  end

  always_comb begin
    item_t       p;
    logic [16:0] f;
    logic        refl;
    p = pipe_r[STG_LAST];
    f = {1'b0, r0_r} + p.fm;
    refl = p.tir | ({1'b0, p.rnd} < f);
    res.total_internal = p.tir;
    res.took_reflect   = refl;
    if (refl) begin
      res.new_x   = neg_sat(p.x);
      res.new_y   = p.y;
      res.new_z   = neg_sat(p.z);
      res.atten_r = p.refl[0];
      res.atten_g = p.refl[1];
      res.atten_b = p.refl[2];
    end else begin
      res.new_x   = refr_sat(p.x, p.vac ? {1'b0, p.c_q[0]} : p.m_mat[0]);
      res.new_y   = p.vac ? 16'(-$signed({1'b0, p.cos_t})) : 16'(p.cos_t);
      res.new_z   = refr_sat(p.z, p.vac ? {1'b0, p.c_q[1]} : p.m_mat[1]);
      res.atten_r = p.vac ? p.ta_vac[0] : p.t_q[0];
      res.atten_g = p.vac ? p.ta_vac[1] : p.t_q[1];
      res.atten_b = p.vac ? p.ta_vac[2] : p.t_q[2];
    end
  end

  // output skid
  assign push = en & v_r[STG_LAST];
  assign pop  = out_v_r & out_ch.ready;

  always_comb begin
    out_v_nxt   = out_v_r;
    out_d_nxt   = out_d_r;
    spare_v_nxt = spare_v_r;
    spare_d_nxt = spare_d_r;
    if (pop || !out_v_r) begin
      if (spare_v_r) begin
        out_v_nxt   = 1'b1;
        out_d_nxt   = spare_d_r;
        spare_v_nxt = 1'b0;
      end else begin
        out_v_nxt = push;
        out_d_nxt = res;
      end
    end else if (push) begin
      spare_v_nxt = 1'b1;
      spare_d_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r   <= 1'b0;
      spare_v_r <= 1'b0;
    end else begin
      out_v_r   <= out_v_nxt;
      spare_v_r <= spare_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r   <= out_d_nxt;
    spare_d_r <= spare_d_nxt;
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.new_x          = out_d_r.new_x;
  assign out_ch.new_y          = out_d_r.new_y;
  assign out_ch.new_z          = out_d_r.new_z;
  assign out_ch.atten_r        = out_d_r.atten_r;
  assign out_ch.atten_g        = out_d_r.atten_g;
  assign out_ch.atten_b        = out_d_r.atten_b;
  assign out_ch.total_internal = out_d_r.total_internal;
  assign out_ch.took_reflect   = out_d_r.took_reflect;

endmodule

@@ src/gfs_checker.sv @@
// ----------------------------------------------------------------------------
// gfs_checker: port-level checks for glass_fresnel_scatter
// Watches reset, result hold, reflection flags and setup after ior writes.
// ----------------------------------------------------------------------------
module gfs_checker import gfs_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic cfg_valid,
  input logic cfg_ready,
  input logic out_valid,
  input logic out_ready,
  input dir_t out_new_x,
  input logic out_total_internal,
  input logic out_took_reflect
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_x) && $stable(out_took_reflect))
    else $error("stalled result changed");

  a_tir_reflects: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_total_internal |-> out_took_reflect)
    else $error("total internal reflection without reflect");

  a_cfg_setup: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready && !cfg_ready)
    else $error("input taken during ior setup");

endmodule

bind glass_fresnel_scatter gfs_checker u_gfs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .cfg_valid          (cfg_ch.valid),
  .cfg_ready          (cfg_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_new_x          (out_ch.new_x),
  .out_total_internal (out_ch.total_internal),
  .out_took_reflect   (out_ch.took_reflect)
);
